// File: sv/assert_macros.svh
// assert_macros.svh: assertion macros used by ring_buffer_deque.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Boolean expression checked at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Property checked at every clock edge out of reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// File: sv/rbd_pkg.sv
// rbd_pkg: operation codes, status codes and cell commands of the deque.
// No dependencies; used by rbd_cell and ring_buffer_deque.
package rbd_pkg;

  typedef enum logic [2:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_BACK   = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_GET        = 3'd4,
    MODE_REMOVE     = 3'd5,
    MODE_CONTAINS   = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // What one cell loads this cycle.
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD      = 2'd1,
    CELL_FROM_PREV = 2'd2,
    CELL_FROM_NEXT = 2'd3
  } cell_op_t;

endpackage

// File: sv/rbd_cell.sv
// rbd_cell: one slot of the deque chain; holds one word, shifts to or from
// its neighbors and compares against the search word. Uses rbd_pkg.
module rbd_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  rbd_pkg::cell_op_t     op,
  input  logic [DATA_WIDTH-1:0] load_data,
  input  logic [DATA_WIDTH-1:0] prev_data,
  input  logic [DATA_WIDTH-1:0] next_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  match
);

  logic [DATA_WIDTH-1:0] data_next;

  always_comb begin
    unique case (op)
      rbd_pkg::CELL_HOLD:      data_next = data;
      rbd_pkg::CELL_LOAD:      data_next = load_data;
      rbd_pkg::CELL_FROM_PREV: data_next = prev_data;
      rbd_pkg::CELL_FROM_NEXT: data_next = next_data;
      default:                 data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign match = (data == load_data);

endmodule

// File: sv/ring_buffer_deque.sv
// ring_buffer_deque: fixed-capacity double-ended queue built as a chain of cells.
// Depends on rbd_pkg, rbd_cell and assert_macros.svh.
//
//   channel   signals                          direction
//   in        in_valid/in_ready, mode,         into block
//             value, index
//   out       out_valid/out_ready, data_out,   out of block
//             found, count, status
//
// Each accepted item is executed in the cycle of its transfer; its result is
// registered and shows in the following cycle. Throughput is one item per cycle as
// long as the result register drains; in_ready drops only while a result
// waits on a low out_ready. Reset clears the entry count and the result
// valid flag; cell contents are not reset (only held entries are read).
module ring_buffer_deque #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [31:0] value,
  input  logic [3:0]  index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] data_out,
  output logic        found,
  output logic [4:0]  count,
  output logic [1:0]  status
);

`include "assert_macros.svh"

  localparam int CW = $clog2(DEPTH + 1);  // entry count width
  localparam int AW = $clog2(DEPTH);      // cell address width

  // Logical order is kept in the chain: cell 0 is always the front entry,
  // so the ring's head pointer never needs to exist in hardware.
  logic [CW-1:0]         entry_count;
  logic [CW-1:0]         entry_count_next;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      cell_match;
  rbd_pkg::cell_op_t     cell_op [DEPTH];

  logic                  in_xfer;
  logic                  full;
  logic                  empty;
  logic                  in_range;
  logic [DATA_WIDTH+31:0] value_ext;
  logic [DATA_WIDTH-1:0] value_w;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH+31:0] rd_ext;
  logic                  any_match;

  logic [31:0]           res_data;
  logic                  res_found;
  rbd_pkg::status_t      res_status;

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // Input word is cut (or zero-extended) to the stored width.
  assign value_ext = {{DATA_WIDTH{1'b0}}, value};
  assign value_w   = value_ext[DATA_WIDTH-1:0];

  assign full     = (entry_count == CW'(DEPTH));
  assign empty    = (entry_count == '0);
  assign in_range = (32'(index) < 32'(entry_count));

  // Single read port on the chain: back entry, front entry or the index.
  always_comb begin
    unique case (rbd_pkg::mode_t'(mode))
      rbd_pkg::MODE_POP_BACK:  rd_addr = AW'(entry_count - CW'(1));
      rbd_pkg::MODE_POP_FRONT: rd_addr = '0;
      default:                 rd_addr = AW'(index);
    endcase
  end

  assign rd_data = cell_data[rd_addr];
  assign rd_ext  = {32'b0, rd_data};

  // Search hit only counts inside the held range.
  always_comb begin
    any_match = 1'b0;
    for (int k = 0; k < DEPTH; k++) begin
      if (cell_match[k] && (32'(k) < 32'(entry_count))) begin
        any_match = 1'b1;
      end
    end
  end

  // Per-cell commands, new count and the result fields.
  always_comb begin
    entry_count_next = entry_count;
    res_data         = '0;
    res_found        = 1'b0;
    res_status       = rbd_pkg::ST_OK;
    for (int k = 0; k < DEPTH; k++) begin
      cell_op[k] = rbd_pkg::CELL_HOLD;
    end

    if (in_xfer) begin
      unique case (rbd_pkg::mode_t'(mode))
        rbd_pkg::MODE_PUSH_BACK: begin
          if (full) begin
            res_status = rbd_pkg::ST_FULL;
          end else begin
            for (int k = 0; k < DEPTH; k++) begin
              if (CW'(k) == entry_count) cell_op[k] = rbd_pkg::CELL_LOAD;
            end
            entry_count_next = entry_count + CW'(1);
          end
        end
        rbd_pkg::MODE_PUSH_FRONT: begin
          if (full) begin
            res_status = rbd_pkg::ST_FULL;
          end else begin
            cell_op[0] = rbd_pkg::CELL_LOAD;
            for (int k = 1; k < DEPTH; k++) begin
              cell_op[k] = rbd_pkg::CELL_FROM_PREV;
            end
            entry_count_next = entry_count + CW'(1);
          end
        end
        rbd_pkg::MODE_POP_BACK: begin
          if (empty) begin
            res_status = rbd_pkg::ST_EMPTY;
          end else begin
            res_data         = rd_ext[31:0];
            entry_count_next = entry_count - CW'(1);
          end
        end
        rbd_pkg::MODE_POP_FRONT: begin
          if (empty) begin
            res_status = rbd_pkg::ST_EMPTY;
          end else begin
            res_data = rd_ext[31:0];
            for (int k = 0; k < DEPTH - 1; k++) begin
              cell_op[k] = rbd_pkg::CELL_FROM_NEXT;
            end
            entry_count_next = entry_count - CW'(1);
          end
        end
        rbd_pkg::MODE_GET: begin
          if (!in_range) begin
            res_status = rbd_pkg::ST_RANGE;
          end else begin
            res_data = rd_ext[31:0];
          end
        end
        rbd_pkg::MODE_REMOVE: begin
          if (!in_range) begin
            res_status = rbd_pkg::ST_RANGE;
          end else begin
            res_data = rd_ext[31:0];
            // Entries behind the removed one close the gap.
            for (int k = 0; k < DEPTH - 1; k++) begin
              if (32'(k) >= 32'(index)) cell_op[k] = rbd_pkg::CELL_FROM_NEXT;
            end
            entry_count_next = entry_count - CW'(1);
          end
        end
        rbd_pkg::MODE_CONTAINS: begin
          res_found = any_match;
        end
        default: begin
          // unused code: no operation
        end
      endcase
    end
  end

  // The chain itself. End cells tie their missing neighbor to something
  // harmless; those paths are never selected.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    rbd_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .op        (cell_op[g]),
      .load_data (value_w),
      .prev_data ((g == 0) ? value_w : cell_data[(g == 0) ? 0 : g - 1]),
      .next_data ((g == DEPTH - 1) ? cell_data[g] : cell_data[(g == DEPTH - 1) ? g : g + 1]),
      .data      (cell_data[g]),
      .match     (cell_match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else begin
      entry_count <= entry_count_next;
    end
  end

  // Result register: loads on every input transfer, which only happens when
  // it is empty or being drained in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      data_out <= res_data;
      found    <= res_found;
      count    <= 5'(entry_count_next);
      status   <= res_status;
    end
  end

  // Checks
  `ASSERT_ALWAYS(a_count_bound, entry_count <= CW'(DEPTH), "entry count above capacity")
  `ASSERT_PROP(a_full_flag,
    (out_valid && status == rbd_pkg::ST_FULL) |-> (count == 5'(DEPTH)),
    "full refusal with room left")
  `ASSERT_PROP(a_empty_flag,
    (out_valid && status == rbd_pkg::ST_EMPTY) |-> (count == 5'd0 && data_out == 32'd0),
    "empty pop with entries or data")
  `ASSERT_PROP(a_push_grows,
    (in_xfer && mode == 3'(rbd_pkg::MODE_PUSH_BACK) && !full)
      |=> (entry_count == $past(entry_count) + CW'(1)),
    "push did not grow count")

endmodule
